// ----- src/mha_pkg.sv -----
// Package for the multi-resolution history averager.
// Holds beat types, store constants and the controller state type; no dependencies.
`default_nettype none
package mha_pkg;

   localparam int MINUTE_DEPTH = 12;
   localparam int HOUR_DEPTH   = 60;
   localparam int DAY_DEPTH    = 48;
   localparam int MONTH_DEPTH  = 56;
   localparam int MONTHS_KEPT  = 1;

   function automatic int at_least_one(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   localparam int P_HOUR  = at_least_one(MINUTE_DEPTH * 60 / HOUR_DEPTH);
   localparam int P_DAY   = at_least_one(MINUTE_DEPTH * 1440 / DAY_DEPTH);
   localparam int P_MONTH = at_least_one(MINUTE_DEPTH * 40320 * MONTHS_KEPT / MONTH_DEPTH);
   localparam int RUN_HOUR  = MINUTE_DEPTH * 60 / HOUR_DEPTH;
   localparam int RUN_DAY   = HOUR_DEPTH * 24 / DAY_DEPTH;
   localparam int RUN_MONTH = DAY_DEPTH * 28 / at_least_one(MONTH_DEPTH / MONTHS_KEPT);
   localparam int U_MIN   = at_least_one(60 / MINUTE_DEPTH);
   localparam int U_HOUR  = at_least_one(3600 / HOUR_DEPTH);
   localparam int U_DAY   = at_least_one(1440 / DAY_DEPTH);
   localparam int U_MONTH = at_least_one(672 * MONTHS_KEPT / MONTH_DEPTH);

   // A cascade period is split into a power of two and an odd part. A count is
   // a multiple of it when its low bits are zero and the shifted count times the
   // inverse of the odd part, modulo 2^32, is at most (2^32-1) over that part.
   function automatic int trail_zeros(input int v);
      int n;
      n = 0;
      for (int i = 0; i < 31; i++) begin
         if (n == i && ((v >> i) & 1) == 0) n = i + 1;
      end
      return n;
   endfunction

   function automatic logic [31:0] odd_inverse(input logic [31:0] d);
      logic [31:0] x;
      x = d;
      for (int i = 0; i < 5; i++) begin
         x = x * (32'd2 - d * x);
      end
      return x;
   endfunction

   localparam int          HOUR_TZ    = trail_zeros(P_HOUR);
   localparam logic [31:0] HOUR_ODD   = 32'(P_HOUR >> HOUR_TZ);
   localparam logic [31:0] HOUR_INV   = odd_inverse(HOUR_ODD);
   localparam logic [31:0] HOUR_LIM   = 32'hFFFF_FFFF / HOUR_ODD;
   localparam logic [31:0] HOUR_MASK  = 32'((1 << HOUR_TZ) - 1);
   localparam int          DAY_TZ     = trail_zeros(P_DAY);
   localparam logic [31:0] DAY_ODD    = 32'(P_DAY >> DAY_TZ);
   localparam logic [31:0] DAY_INV    = odd_inverse(DAY_ODD);
   localparam logic [31:0] DAY_LIM    = 32'hFFFF_FFFF / DAY_ODD;
   localparam logic [31:0] DAY_MASK   = 32'((1 << DAY_TZ) - 1);
   localparam int          MONTH_TZ   = trail_zeros(P_MONTH);
   localparam logic [31:0] MONTH_ODD  = 32'(P_MONTH >> MONTH_TZ);
   localparam logic [31:0] MONTH_INV  = odd_inverse(MONTH_ODD);
   localparam logic [31:0] MONTH_LIM  = 32'hFFFF_FFFF / MONTH_ODD;
   localparam logic [31:0] MONTH_MASK = 32'((1 << MONTH_TZ) - 1);

   // Window lengths are capped at the store depth, at most 60, the largest store depth.
   localparam int WIN_W  = 7;
   localparam int SLOT_W = 6;
   localparam int SUM_W  = 24;

   localparam logic [1:0] LVL_MIN   = 2'd0;
   localparam logic [1:0] LVL_HOUR  = 2'd1;
   localparam logic [1:0] LVL_DAY   = 2'd2;
   localparam logic [1:0] LVL_MONTH = 2'd3;

   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [4:0] LAST_CODE = 5'd18;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] sample;
      logic [31:0]        cycle_count;
      logic [4:0]         interval;
   } req_type;

   typedef struct packed {
      logic signed [15:0] average;
      logic               is_missing;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PUSH, ST_CHK, ST_CLEAR, ST_INIT, ST_RD, ST_ACC,
      ST_DIV, ST_WB, ST_RAW, ST_RAW2, ST_OUT
   } state_type;

   // Command from controller to datapath.
   typedef struct packed {
      logic       clear_step;
      logic       push_write;
      logic       run_init;
      logic       read_issue;
      logic       acc_step;
      logic       div_start;
      logic       div_step;
      logic       wb_write;
      logic       raw_issue;
      logic       raw_take;
      logic       load_unknown;
      logic [1:0] level;
      logic [WIN_W-1:0] win;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic run_done;
      logic div_done;
   } sts_type;

   function automatic logic [WIN_W-1:0] cap(input int w, input int d);
      int r;
      r = (w > d) ? d : w;
      return WIN_W'(r);
   endfunction

   function automatic logic [WIN_W-1:0] query_win(input logic [4:0] code);
      logic [WIN_W-1:0] w;
      case (code)
         5'd0:  w = '0;
         5'd1:  w = cap(10 / U_MIN, MINUTE_DEPTH);
         5'd2:  w = cap(20 / U_MIN, MINUTE_DEPTH);
         5'd3:  w = cap(30 / U_MIN, MINUTE_DEPTH);
         5'd4:  w = cap(60 / U_MIN, MINUTE_DEPTH);
         5'd5:  w = cap(120 / U_HOUR, HOUR_DEPTH);
         5'd6:  w = cap(300 / U_HOUR, HOUR_DEPTH);
         5'd7:  w = cap(900 / U_HOUR, HOUR_DEPTH);
         5'd8:  w = cap(1800 / U_HOUR, HOUR_DEPTH);
         5'd9:  w = cap(3600 / U_HOUR, HOUR_DEPTH);
         5'd10: w = cap(120 / U_DAY, DAY_DEPTH);
         5'd11: w = cap(180 / U_DAY, DAY_DEPTH);
         5'd12: w = cap(240 / U_DAY, DAY_DEPTH);
         5'd13: w = cap(360 / U_DAY, DAY_DEPTH);
         5'd14: w = cap(720 / U_DAY, DAY_DEPTH);
         5'd15: w = cap(1440 / U_DAY, DAY_DEPTH);
         5'd16: w = cap(48 / U_MONTH, MONTH_DEPTH);
         5'd17: w = cap(168 / U_MONTH, MONTH_DEPTH);
         5'd18: w = cap(336 / U_MONTH, MONTH_DEPTH);
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] query_level(input logic [4:0] code);
      logic [1:0] l;
      if (code <= 5'd4) begin
         l = LVL_MIN;
      end else if (code <= 5'd9) begin
         l = LVL_HOUR;
      end else if (code <= 5'd15) begin
         l = LVL_DAY;
      end else begin
         l = LVL_MONTH;
      end
      return l;
   endfunction

endpackage
`default_nettype wire

// ----- src/mha_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ----- src/mha_datapath.sv -----
// Datapath: four ring stores, slot pointers, run accumulator and serial divider.
// Depends on mha_pkg and mha_ram.
`default_nettype none
module mha_datapath
   import mha_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire req_type            req,
   input  wire logic signed [15:0] missing,
   output sts_type                 sts,
   output rsp_type                 result
);
   localparam int DIV_W = SUM_W + 1;

   logic [SLOT_W-1:0] slot_ff [4];
   logic [SLOT_W-1:0] slot_in [4];
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [WIN_W-1:0]  cnt_ff, cnt_in, n_ff, n_in;
   logic              stop_ff, stop_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [DIV_W-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]        dstep_ff, dstep_in;
   logic              neg_ff, neg_in;
   rsp_type           res_ff, res_in;

   logic [SLOT_W-1:0] addr [4];
   logic [3:0]        we;
   logic [15:0]       wdata;
   logic [15:0]       rdata [4];
   logic signed [15:0] rd_sel;
   logic [1:0]        src;
   logic [SLOT_W-1:0] depth_m1 [4];
   logic [SLOT_W-1:0] src_m1;
   logic [DIV_W-1:0]  den, shifted;
   logic [SUM_W-1:0]  mag;
   logic signed [15:0] mean;

   assign depth_m1[0] = SLOT_W'(MINUTE_DEPTH - 1);
   assign depth_m1[1] = SLOT_W'(HOUR_DEPTH - 1);
   assign depth_m1[2] = SLOT_W'(DAY_DEPTH - 1);
   assign depth_m1[3] = SLOT_W'(MONTH_DEPTH - 1);

   // Cascades read the next finer store; queries read their own store.
   assign src = (cmd.wb_write || cmd.div_start || cmd.div_step || cmd.acc_step ||
                 cmd.read_issue || cmd.run_init) && (cmd.level != LVL_MIN) &&
                !req.mode ? cmd.level - 2'd1 : cmd.level;
   assign src_m1 = depth_m1[src];
   assign rd_sel = rdata[src];
   assign mean = neg_ff ? -16'(quo_ff) : 16'(quo_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         addr[k] = slot_ff[k];
         we[k]   = cmd.clear_step;
         if (cmd.clear_step) addr[k] = (clr_ff > depth_m1[k]) ? '0 : clr_ff;
      end
      wdata = cmd.clear_step ? missing : 16'(req.sample);
      if (cmd.push_write) begin
         we[0] = 1'b1;
         addr[0] = (slot_ff[0] == depth_m1[0]) ? '0 : slot_ff[0] + 1'b1;
      end
      // Only a cascade stores its mean; a query leaves the stores alone.
      if (cmd.wb_write && req.mode == MODE_PUSH) begin
         we[cmd.level] = 1'b1;
         addr[cmd.level] = (slot_ff[cmd.level] == depth_m1[cmd.level]) ? '0 :
                           slot_ff[cmd.level] + 1'b1;
         wdata = (n_ff == '0) ? missing : mean;
      end
      if (cmd.read_issue || cmd.acc_step) addr[src] = idx_ff;
      if (cmd.raw_issue || cmd.raw_take) addr[src] = slot_ff[src];
   end

   for (genvar g = 0; g < 4; g++) begin : g_store
      localparam int D = (g == 0) ? MINUTE_DEPTH : (g == 1) ? HOUR_DEPTH :
                         (g == 2) ? DAY_DEPTH : MONTH_DEPTH;
      mha_ram #(.WIDTH(16), .DEPTH(D)) u_ram (
         .clock  (clock),
         .wr_en  (we[g]),
         .addr   (addr[g][$clog2(D)-1:0]),
         .wr_data(wdata),
         .rd_data(rdata[g])
      );
   end

   assign mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign den = DIV_W'({n_ff, 1'b0});
   assign shifted = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};

   always_comb begin
      slot_in = slot_ff;
      clr_in = clr_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      stop_in = stop_ff;
      sum_in = sum_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dstep_in = dstep_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      if (cmd.clear_step) clr_in = clr_ff + 1'b1;
      if (cmd.push_write) slot_in[0] = addr[0];
      if (cmd.wb_write && req.mode == MODE_PUSH) slot_in[cmd.level] = addr[cmd.level];
      if (cmd.run_init) begin
         idx_in = slot_ff[src];
         cnt_in = '0;
         n_in = '0;
         sum_in = '0;
         stop_in = 1'b0;
      end
      if (cmd.acc_step) begin
         if (!stop_ff && cnt_ff < cmd.win && rd_sel != missing) begin
            sum_in = sum_ff + SUM_W'(rd_sel);
            n_in = n_ff + 1'b1;
         end else begin
            stop_in = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
         idx_in = (idx_ff == '0) ? src_m1 : idx_ff - 1'b1;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = DIV_W'({mag, 1'b0}) + DIV_W'(n_ff);
         dstep_in = '0;
         neg_in = sum_ff[SUM_W-1];
      end
      if (cmd.div_step) begin
         if (shifted >= den) begin
            rem_in = shifted - den;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         dstep_in = dstep_ff + 1'b1;
      end
      if (cmd.raw_take) begin
         res_in.average = rd_sel;
         res_in.is_missing = (rd_sel == missing);
      end
      if (cmd.load_unknown) begin
         res_in.average = missing;
         res_in.is_missing = 1'b1;
      end
      if (cmd.wb_write && req.mode == MODE_QUERY) begin
         res_in.average = (n_ff == '0) ? missing : mean;
         res_in.is_missing = (n_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff[0] <= SLOT_W'(MINUTE_DEPTH - 1);
         slot_ff[1] <= SLOT_W'(HOUR_DEPTH - 1);
         slot_ff[2] <= SLOT_W'(DAY_DEPTH - 1);
         slot_ff[3] <= SLOT_W'(MONTH_DEPTH - 1);
         clr_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         clr_ff <= clr_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      stop_ff <= stop_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dstep_ff <= dstep_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign sts.clear_done = (clr_ff == SLOT_W'(63));
   assign sts.run_done = stop_ff || (cnt_ff >= cmd.win);
   assign sts.div_done = (dstep_ff == 5'(DIV_W - 1));
   assign result = res_ff;
endmodule
`default_nettype wire

// ----- src/mha_ctrl.sv -----
// Controller state machine: clear pass, push cascade and query sequencing.
// Depends on mha_pkg.
`default_nettype none
module mha_ctrl
   import mha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_take,
   input  wire req_type req,
   input  wire logic    rsp_take,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);
   state_type state_ff, state_in;
   logic [1:0] lvl_ff, lvl_in;
   logic [31:0] per_sel, mask_sel, inv_sel, lim_sel, scaled, prod;
   logic        due_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lvl_ff <= LVL_MIN;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
      end
   end

   // Period check for the level under test, by multiplying with the inverse
   // of the period's odd part.
   always_comb begin
      case (lvl_ff)
         LVL_HOUR: begin
            per_sel = 32'(P_HOUR);
            mask_sel = HOUR_MASK;
            inv_sel = HOUR_INV;
            lim_sel = HOUR_LIM;
            scaled = req.cycle_count >> HOUR_TZ;
         end
         LVL_DAY: begin
            per_sel = 32'(P_DAY);
            mask_sel = DAY_MASK;
            inv_sel = DAY_INV;
            lim_sel = DAY_LIM;
            scaled = req.cycle_count >> DAY_TZ;
         end
         default: begin
            per_sel = 32'(P_MONTH);
            mask_sel = MONTH_MASK;
            inv_sel = MONTH_INV;
            lim_sel = MONTH_LIM;
            scaled = req.cycle_count >> MONTH_TZ;
         end
      endcase
      prod = scaled * inv_sel;
      due_now = (req.cycle_count >= per_sel) &&
                ((req.cycle_count & mask_sel) == 32'd0) && (prod <= lim_sel);
   end

   always_comb begin
      state_in = state_ff;
      lvl_in = lvl_ff;
      cmd = '0;
      cmd.level = lvl_ff;
      if (req.mode == MODE_QUERY) begin
         cmd.win = query_win(req.interval);
      end else begin
         case (lvl_ff)
            LVL_HOUR: cmd.win = WIN_W'(RUN_HOUR > MINUTE_DEPTH ? MINUTE_DEPTH : RUN_HOUR);
            LVL_DAY:  cmd.win = WIN_W'(RUN_DAY > HOUR_DEPTH ? HOUR_DEPTH : RUN_DAY);
            default:  cmd.win = WIN_W'(RUN_MONTH > DAY_DEPTH ? DAY_DEPTH : RUN_MONTH);
         endcase
      end
      busy = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (req_take) begin
               if (req.mode == MODE_PUSH) begin
                  state_in = ST_PUSH;
               end else if (req.interval > LAST_CODE) begin
                  state_in = ST_OUT;
                  cmd.load_unknown = 1'b1;
               end else begin
                  lvl_in = query_level(req.interval);
                  state_in = (query_win(req.interval) == '0) ? ST_RAW : ST_INIT;
               end
            end
         end
         ST_PUSH: begin
            cmd.push_write = 1'b1;
            lvl_in = LVL_HOUR;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (lvl_ff == LVL_MIN) begin
               state_in = ST_IDLE;
            end else if (due_now) begin
               state_in = ST_INIT;
            end else begin
               lvl_in = lvl_ff + 2'd1;
            end
         end
         ST_INIT: begin
            cmd.run_init = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd.read_issue = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sts.run_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.acc_step = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_WB;
         end
         ST_WB: begin
            if (req.mode == MODE_QUERY) begin
               cmd.wb_write = 1'b0;
               state_in = ST_OUT;
            end else begin
               cmd.wb_write = 1'b1;
               lvl_in = lvl_ff + 2'd1;
               state_in = ST_CHK;
            end
         end
         ST_RAW: begin
            cmd.raw_issue = 1'b1;
            state_in = ST_RAW2;
         end
         ST_RAW2: begin
            cmd.raw_take = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // A finished query captures its mean through the write-back path.
      if (state_ff == ST_WB && req.mode == MODE_QUERY) cmd.wb_write = 1'b1;
   end
endmodule
`default_nettype wire

// ----- src/multires_history_averager_unit.sv -----
// Top level of the multi-resolution history averager.
// Depends on mha_pkg, mha_ctrl, mha_datapath and mha_ram.
//
//   channel   direction   beat / handshake
//   req_      in          req_type, req_valid / req_stall
//   rsp_      out         rsp_type, rsp_valid / rsp_stall
//   csr_      in          16-bit missing code, csr_write
//
// One beat is handled at a time. A push holds the input while the sample is
// written and each due cascade level is averaged: the entries are read one by
// one, then a 25-step restoring divider runs. A query reads its window from its
// own store, and its run ends early when a missing entry is met; a zero window
// returns the latest entry raw, an unknown code returns the missing code.
// After reset a clearing pass fills every store with the missing code and no
// beat is taken; a stalled result holds and keeps the input stalled.
`default_nettype none
module multires_history_averager_unit
   import mha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic signed [15:0] csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic busy, req_take, rsp_take;
   logic signed [15:0] missing_ff;
   req_type req_ff, req_cur;

   assign req_stall = busy;
   assign req_take = req_valid && !busy;
   assign rsp_take = rsp_valid && !rsp_stall;
   // The accepting cycle decodes the live beat; later cycles use the held copy.
   assign req_cur = req_take ? req_data : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         missing_ff <= -16'sd32768;
      end else if (csr_write) begin
         missing_ff <= csr_data;
      end
      if (req_take) req_ff <= req_data;
   end

   mha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_take(req_take), .req(req_cur),
      .rsp_take(rsp_take), .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   mha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_cur),
      .missing(missing_ff), .sts(sts), .result(rsp_data)
   );

`ifndef ASSERT_OFF
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_take) else $error("beat taken while busy");
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");
   a_missing_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_missing && $past(!csr_write)) |->
      rsp_data.average == missing_ff) else $error("missing flag without code");
`endif
endmodule
`default_nettype wire
